// ===== sv/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and codes for the CBOR stream tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int MAX_NESTING_DEF = 16;
  localparam int ARG_W = 64;

  // level entry width: items left plus indefinite flag
  localparam int LVL_W = ARG_W + 1;

  // parse phases
  localparam logic [1:0] PH_HEAD    = 2'd0;
  localparam logic [1:0] PH_ARG     = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  // sequencer states
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;

  // token kinds
  localparam logic [2:0] K_HEAD    = 3'd0;
  localparam logic [2:0] K_PAYLOAD = 3'd1;
  localparam logic [2:0] K_BREAK   = 3'd2;
  localparam logic [2:0] K_ERROR   = 3'd3;
  localparam logic [2:0] K_END     = 3'd4;

  // error codes
  localparam logic [2:0] E_NONE      = 3'd0;
  localparam logic [2:0] E_RESERVED  = 3'd1;
  localparam logic [2:0] E_BAD_INDEF = 3'd2;
  localparam logic [2:0] E_CHUNK     = 3'd3;
  localparam logic [2:0] E_NESTED    = 3'd4;
  localparam logic [2:0] E_BREAK     = 3'd5;
  localparam logic [2:0] E_OVERFLOW  = 3'd6;
  localparam logic [2:0] E_TRUNC     = 3'd7;

  // head byte fields
  localparam logic [2:0] MT_BSTR  = 3'd2;
  localparam logic [2:0] MT_TSTR  = 3'd3;
  localparam logic [2:0] MT_ARRAY = 3'd4;
  localparam logic [2:0] MT_MAP   = 3'd5;
  localparam logic [2:0] MT_TAG   = 3'd6;
  localparam logic [2:0] MT_SIMPLE = 3'd7;
  localparam logic [4:0] AI_ARG1  = 5'd24;
  localparam logic [4:0] AI_RSV_LO = 5'd28;
  localparam logic [4:0] AI_RSV_HI = 5'd30;
  localparam logic [4:0] AI_INDEF = 5'd31;
  localparam logic [7:0] BREAK_BYTE = 8'hFF;

  // result of one completion step on the top level
  typedef struct packed {
    logic done;
    logic load;
  } step_t;

  // token without its nesting level and done mark
  typedef struct packed {
    logic [2:0]       kind;
    logic [2:0]       major;
    logic [4:0]       info;
    logic [ARG_W-1:0] arg;
    logic             indef;
    logic [7:0]       data;
    logic [2:0]       err;
  } tok_t;

endpackage

// ===== sv/cst_stack_mem.sv =====
// ----------------------------------------------------------------------------
// cst_stack_mem
// Level store below the cached stack top; one write and one registered read.
// ----------------------------------------------------------------------------
module cst_stack_mem #(
  parameter int DEPTH = cst_pkg::MAX_NESTING_DEF,
  parameter int AW    = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [cst_pkg::LVL_W-1:0] wr_data,
  input  logic [AW-1:0]            rd_addr,
  output logic [cst_pkg::LVL_W-1:0] rd_data
);
  import cst_pkg::*;

  logic [LVL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/cst_level_step.sv =====
// ----------------------------------------------------------------------------
// cst_level_step
// One completion step: count an item at the top level, pop when it runs out.
// ----------------------------------------------------------------------------
module cst_level_step #(
  parameter int SPW = 5
) (
  input  logic [SPW-1:0]           sp,
  input  logic [cst_pkg::ARG_W-1:0] cnt,
  input  logic                     indef,
  output cst_pkg::step_t           stp,
  output logic [SPW-1:0]           sp_new,
  output logic [cst_pkg::ARG_W-1:0] cnt_new
);
  import cst_pkg::*;

  // decrement the top, pop on zero, ask for a reload if levels remain
  always_comb begin
    stp     = '0;
    sp_new  = sp;
    cnt_new = cnt;
    if (sp == '0) begin
      stp.done = 1'b1;
    end else if (!indef) begin
      if (cnt != ARG_W'(1)) begin
        cnt_new = cnt - ARG_W'(1);
      end else begin
        sp_new = sp - SPW'(1);
        if (sp == SPW'(1)) begin
          stp.done = 1'b1;
        end else begin
          stp.load = 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/cbor_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// cbor_stream_tokenizer
// Streaming CBOR tokenizer with a memory-backed nesting stack.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, unless held off as below, and gives at most
// one token. The open level on top of the nesting stack is held in registers
// and the levels below it sit in a one-port-read memory with a registered
// read. Whenever a level is popped and another stays open (an exhausted
// definite container or a break), the new top must be fetched: each such pop
// adds a read state and then a count state before the token appears, and no
// byte is taken meanwhile. Every other byte is taken back to back. A token
// waiting in the output register holds off the input until it is taken; in
// the cycle in which it leaves, the next byte is taken as well.
// ----------------------------------------------------------------------------
module cbor_stream_tokenizer #(
  parameter int MAX_NESTING = cst_pkg::MAX_NESTING_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_byte,
  input  logic                      stream_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                token_kind,
  output logic [2:0]                major_type,
  output logic [4:0]                additional_info,
  output logic [cst_pkg::ARG_W-1:0] argument,
  output logic                      indefinite,
  output logic [7:0]                data_byte,
  output logic [4:0]                nesting_level,
  output logic                      item_done,
  output logic [2:0]                error_code
);
  import cst_pkg::*;

  localparam int SPW = $clog2(MAX_NESTING + 1);
  localparam int AW  = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  // control registers
  logic [1:0]       state, state_next;
  logic [1:0]       phase, phase_next;
  logic [3:0]       arg_left, arg_left_next;
  logic [ARG_W-1:0] acc, acc_next;
  logic [7:0]       head, head_next;
  logic [ARG_W-1:0] pay_left, pay_left_next;
  logic             istr, istr_next;
  logic [2:0]       istr_type, istr_type_next;
  logic [SPW-1:0]   sp, sp_next;
  logic             tag, tag_next;
  logic             err, err_next;

  // cached stack top
  logic [ARG_W-1:0] top_cnt, top_cnt_next;
  logic             top_indef, top_indef_next;

  // token waiting on a stack reload
  tok_t             pend, pend_next;

  // output register
  logic             ov;
  tok_t             otok;
  logic [4:0]       olvl;
  logic             odone;

  // memory ports
  logic             wr_en;
  logic [LVL_W-1:0] rd_data;

  // step unit
  step_t            stp;
  logic [SPW-1:0]   stp_sp;
  logic [ARG_W-1:0] stp_cnt;

  // datapath results
  logic             emit;
  tok_t             tok;
  logic             tok_done;
  logic             slot_free;
  logic             take;

  // resolve request and container push
  logic             rs_go;
  logic [7:0]       rs_head;
  logic [ARG_W-1:0] rs_arg;
  logic             use_cmp;
  logic             do_push;
  logic [ARG_W-1:0] push_cnt;
  logic             push_ind;
  logic [2:0]       hb_major;
  logic [4:0]       hb_info;
  logic [2:0]       rs_major;
  logic [ARG_W-1:0] map_n;

  assign slot_free = !ov || out_ready;
  assign in_ready  = (state == ST_RUN) && slot_free;
  assign take      = in_valid && in_ready;
  assign hb_major  = in_byte[7:5];
  assign hb_info   = in_byte[4:0];
  assign rs_major  = rs_head[7:5];

  cst_level_step #(.SPW(SPW)) u_step (
    .sp      (sp),
    .cnt     (top_cnt),
    .indef   (top_indef),
    .stp     (stp),
    .sp_new  (stp_sp),
    .cnt_new (stp_cnt)
  );

  cst_stack_mem #(.DEPTH(MAX_NESTING), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(sp - SPW'(1))),
    .wr_data ({top_indef, top_cnt}),
    .rd_addr (AW'(sp_next - SPW'(1))),
    .rd_data (rd_data)
  );

  // parser and stack sequencer
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    arg_left_next  = arg_left;
    acc_next       = acc;
    head_next      = head;
    pay_left_next  = pay_left;
    istr_next      = istr;
    istr_type_next = istr_type;
    sp_next        = sp;
    tag_next       = tag;
    err_next       = err;
    top_cnt_next   = top_cnt;
    top_indef_next = top_indef;
    pend_next      = pend;
    emit           = 1'b0;
    tok            = '0;
    tok_done       = 1'b0;
    wr_en          = 1'b0;
    rs_go          = 1'b0;
    rs_head        = head;
    rs_arg         = '0;
    use_cmp        = 1'b0;
    do_push        = 1'b0;
    push_cnt       = '0;
    push_ind       = 1'b0;
    map_n          = '0;

    case (state)
      ST_RUN: begin
        if (take && !err) begin
          if (stream_end) begin
            emit = 1'b1;
            if (phase == PH_HEAD && sp == '0 && !istr && !tag) begin
              tok.kind = K_END;
            end else begin
              tok.kind = K_ERROR;
              tok.err  = E_TRUNC;
              err_next = 1'b1;
            end
          end else if (phase == PH_ARG) begin
            // gather argument bytes big-endian
            acc_next      = {acc[ARG_W-9:0], in_byte};
            arg_left_next = arg_left - 4'd1;
            if (arg_left == 4'd1) begin
              rs_go   = 1'b1;
              rs_head = head;
              rs_arg  = {acc[ARG_W-9:0], in_byte};
            end
          end else if (phase == PH_PAYLOAD) begin
            // string payload byte
            emit          = 1'b1;
            tok.kind      = K_PAYLOAD;
            tok.major     = head[7:5];
            tok.info      = head[4:0];
            tok.data      = in_byte;
            pay_left_next = pay_left - ARG_W'(1);
            if (pay_left == ARG_W'(1)) begin
              phase_next = PH_HEAD;
              use_cmp    = !istr;
            end
          end else begin
            head_next = in_byte;
            if (in_byte == BREAK_BYTE) begin
              emit      = 1'b1;
              tok.kind  = K_BREAK;
              tok.major = MT_SIMPLE;
              tok.info  = AI_INDEF;
              if (istr) begin
                istr_next = 1'b0;
                use_cmp   = 1'b1;
              end else if (tag || sp == '0 || !top_indef) begin
                tok      = '0;
                tok.kind = K_ERROR;
                tok.err  = E_BREAK;
                err_next = 1'b1;
              end else begin
                // close the indefinite level, then count it one level down
                sp_next = sp - SPW'(1);
                if (sp == SPW'(1)) begin
                  tok_done = 1'b1;
                end else begin
                  emit       = 1'b0;
                  pend_next  = tok;
                  state_next = ST_LOAD;
                end
              end
            end else if (istr && hb_major != istr_type) begin
              emit     = 1'b1;
              tok.kind = K_ERROR;
              tok.err  = E_CHUNK;
              err_next = 1'b1;
            end else if (istr && hb_info == AI_INDEF) begin
              emit     = 1'b1;
              tok.kind = K_ERROR;
              tok.err  = E_NESTED;
              err_next = 1'b1;
            end else if (hb_info >= AI_RSV_LO && hb_info <= AI_RSV_HI) begin
              emit     = 1'b1;
              tok.kind = K_ERROR;
              tok.err  = E_RESERVED;
              err_next = 1'b1;
            end else if (hb_info == AI_INDEF) begin
              emit = 1'b1;
              if (hb_major == MT_BSTR || hb_major == MT_TSTR) begin
                istr_next      = 1'b1;
                istr_type_next = hb_major;
                tag_next       = 1'b0;
                tok.major      = hb_major;
                tok.info       = hb_info;
                tok.indef      = 1'b1;
              end else if (hb_major == MT_ARRAY || hb_major == MT_MAP) begin
                do_push   = 1'b1;
                push_ind  = 1'b1;
                tag_next  = 1'b0;
                tok.major = hb_major;
                tok.info  = hb_info;
                tok.indef = 1'b1;
              end else begin
                tok.kind = K_ERROR;
                tok.err  = E_BAD_INDEF;
                err_next = 1'b1;
              end
            end else if (hb_info >= AI_ARG1) begin
              arg_left_next = 4'd1 << hb_info[1:0];
              acc_next      = '0;
              phase_next    = PH_ARG;
            end else begin
              rs_go   = 1'b1;
              rs_head = in_byte;
              rs_arg  = ARG_W'(hb_info);
            end
          end
        end

        // a definite head with its full argument
        if (rs_go) begin
          emit       = 1'b1;
          phase_next = PH_HEAD;
          tok.kind   = K_HEAD;
          tok.major  = rs_major;
          tok.info   = rs_head[4:0];
          tok.arg    = rs_arg;
          if (istr) begin
            pay_left_next = rs_arg;
            if (rs_arg != '0) begin
              phase_next = PH_PAYLOAD;
            end
          end else if (rs_major == MT_TAG) begin
            tag_next = 1'b1;
          end else if (rs_major == MT_ARRAY || rs_major == MT_MAP) begin
            map_n    = (rs_major == MT_MAP) ? {rs_arg[ARG_W-2:0], 1'b0} : rs_arg;
            tag_next = 1'b0;
            if (rs_major == MT_MAP && rs_arg[ARG_W-1]) begin
              tok      = '0;
              tok.kind = K_ERROR;
              tok.err  = E_OVERFLOW;
              err_next = 1'b1;
            end else if (map_n != '0) begin
              do_push  = 1'b1;
              push_cnt = map_n;
            end else begin
              use_cmp = 1'b1;
            end
          end else begin
            tag_next = 1'b0;
            if ((rs_major == MT_BSTR || rs_major == MT_TSTR) && rs_arg != '0) begin
              pay_left_next = rs_arg;
              phase_next    = PH_PAYLOAD;
            end else begin
              use_cmp = 1'b1;
            end
          end
        end

        // open a level: old top goes to memory
        if (do_push) begin
          if (sp >= SPW'(MAX_NESTING)) begin
            tok      = '0;
            tok.kind = K_ERROR;
            tok.err  = E_OVERFLOW;
            err_next = 1'b1;
          end else begin
            wr_en          = (sp != '0);
            top_cnt_next   = push_cnt;
            top_indef_next = push_ind;
            sp_next        = sp + SPW'(1);
          end
        end

        // item finished: count it at the enclosing level
        if (use_cmp) begin
          sp_next      = stp_sp;
          top_cnt_next = stp_cnt;
          tok_done     = stp.done;
          if (stp.load) begin
            emit       = 1'b0;
            pend_next  = tok;
            state_next = ST_LOAD;
          end
        end
      end

      ST_LOAD: begin
        // new top arrives from memory
        top_cnt_next   = rd_data[ARG_W-1:0];
        top_indef_next = rd_data[LVL_W-1];
        state_next     = ST_STEP;
      end

      ST_STEP: begin
        if (slot_free) begin
          sp_next      = stp_sp;
          top_cnt_next = stp_cnt;
          if (stp.load) begin
            state_next = ST_LOAD;
          end else begin
            emit       = 1'b1;
            tok        = pend;
            tok_done   = stp.done;
            state_next = ST_RUN;
          end
        end
      end

      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      phase     <= PH_HEAD;
      arg_left  <= '0;
      acc       <= '0;
      head      <= '0;
      pay_left  <= '0;
      istr      <= 1'b0;
      istr_type <= '0;
      sp        <= '0;
      tag       <= 1'b0;
      err       <= 1'b0;
      ov        <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      arg_left  <= arg_left_next;
      acc       <= acc_next;
      head      <= head_next;
      pay_left  <= pay_left_next;
      istr      <= istr_next;
      istr_type <= istr_type_next;
      sp        <= sp_next;
      tag       <= tag_next;
      err       <= err_next;
      if (emit) begin
        ov <= 1'b1;
      end else if (out_ready) begin
        ov <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_cnt   <= top_cnt_next;
    top_indef <= top_indef_next;
    pend      <= pend_next;
    if (emit) begin
      otok  <= tok;
      olvl  <= 5'(sp_next);
      odone <= tok_done;
    end
  end

  assign out_valid       = ov;
  assign token_kind      = otok.kind;
  assign major_type      = otok.major;
  assign additional_info = otok.info;
  assign argument        = otok.arg;
  assign indefinite      = otok.indef;
  assign data_byte       = otok.data;
  assign nesting_level   = olvl;
  assign item_done       = odone;
  assign error_code      = otok.err;

  // stack depth never passes the limit
  a_sp_bound : assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(MAX_NESTING))
    else $error("stack pointer beyond limit");

  // a reload always targets an open level
  a_load_level : assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (sp != '0))
    else $error("reload with empty stack");

  // nothing is emitted once an error has latched
  a_err_quiet : assert property (@(posedge clk) disable iff (rst)
    err |-> !emit)
    else $error("token after error");

  // a reload never overlaps a stack write
  a_no_wr_reload : assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> !wr_en)
    else $error("stack write during reload");

endmodule

// ===== dv/cbor_stream_tokenizer_test.sv =====
// ----------------------------------------------------------------------------
// cbor_stream_tokenizer_test
// Self-checking test of the CBOR stream tokenizer. Encoded streams are built
// from random well-formed items (scalars, definite and indefinite strings,
// arrays, maps, tags, floats, deep nesting chains) with end-of-stream marks
// between top-level items. A built-in tokenizer predicts every token, and
// each token that the block hands out is compared with the oldest prediction.
// One error scenario, chosen at random, closes the run.
// ----------------------------------------------------------------------------
module cbor_stream_tokenizer_test;
  import cst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MT_UINT = 3'd0;
  localparam logic [2:0] MT_NINT = 3'd1;
  localparam int         DEPTH   = MAX_NESTING_DEF;
  localparam int         HOLD_CYCLES = 400;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  major;
    logic [4:0]  info;
    logic [63:0] arg;
    logic        indef;
    logic [7:0]  data;
    logic [4:0]  level;
    logic        done;
    logic [2:0]  err;
  } token_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        stream_end;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  token_kind;
  logic [2:0]  major_type;
  logic [4:0]  additional_info;
  logic [63:0] argument;
  logic        indefinite;
  logic [7:0]  data_byte;
  logic [4:0]  nesting_level;
  logic        item_done;
  logic [2:0]  error_code;

  cbor_stream_tokenizer i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .stream_end      (stream_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .token_kind      (token_kind),
    .major_type      (major_type),
    .additional_info (additional_info),
    .argument        (argument),
    .indefinite      (indefinite),
    .data_byte       (data_byte),
    .nesting_level   (nesting_level),
    .item_done       (item_done),
    .error_code      (error_code)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ------------------------------------------------------------------
  // shadow tokenizer state
  // ------------------------------------------------------------------
  logic [1:0]  phase;
  int unsigned arg_left;
  logic [63:0] arg_acc;
  logic [7:0]  held_head;
  logic [63:0] payload_left;
  bit          in_chunked;
  logic [2:0]  chunked_type;
  logic [63:0] level_count [DEPTH];
  bit          level_open_ended [DEPTH];
  int          depth_now;
  bit          tag_waiting;
  bit          halted;

  token_t      expected_tokens [$];
  logic [8:0]  stim_q [$];

  int  fails = 0;
  int  mismatches = 0;
  int  tokens_seen = 0;
  int  bytes_sent = 0;
  int  ends_sent = 0;
  bit  no_idle = 1'b0;
  int  hold_reqs = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  function automatic void note(logic [2:0] kind, logic [2:0] mt, logic [4:0] ai,
                               logic [63:0] a, logic indef, logic [7:0] d,
                               logic done, logic [2:0] err);
    token_t t;
    t = '{kind, mt, ai, a, indef, d, depth_now[4:0], done, err};
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  function automatic void raise(logic [2:0] err);
    halted = 1'b1;
    note(K_ERROR, 3'd0, 5'd0, 64'd0, 1'b0, 8'd0, 1'b0, err);
  endfunction

  // count one finished item at the enclosing level, closing exhausted levels
  function automatic bit close_levels();
    int t;
    while (depth_now != 0) begin
      t = depth_now - 1;
      if (level_open_ended[t]) return 1'b0;
      level_count[t] = level_count[t] - 1;
      if (level_count[t] != 0) return 1'b0;
      depth_now--;
    end
    return 1'b1;
  endfunction

  function automatic bit open_level(logic [63:0] n, bit open_ended);
    if (depth_now >= DEPTH) return 1'b0;
    level_count[depth_now] = n;
    level_open_ended[depth_now] = open_ended;
    depth_now++;
    return 1'b1;
  endfunction

  // head with its full argument
  function automatic void finish_head(logic [7:0] h, logic [63:0] a);
    logic [2:0]  mt;
    logic [4:0]  ai;
    logic [63:0] n;
    bit          done;
    mt = h[7:5];
    ai = h[4:0];
    done = 1'b0;
    phase = PH_HEAD;
    if (in_chunked) begin
      payload_left = a;
      if (a != 0) phase = PH_PAYLOAD;
      note(K_HEAD, mt, ai, a, 1'b0, 8'd0, 1'b0, E_NONE);
      return;
    end
    if (mt == MT_TAG) begin
      tag_waiting = 1'b1;
      note(K_HEAD, mt, ai, a, 1'b0, 8'd0, 1'b0, E_NONE);
      return;
    end
    if (mt == MT_ARRAY || mt == MT_MAP) begin
      n = a;
      if (mt == MT_MAP) begin
        if (a[63]) begin
          raise(E_OVERFLOW);
          return;
        end
        n = a << 1;
      end
      if (n != 0) begin
        if (!open_level(n, 1'b0)) begin
          raise(E_OVERFLOW);
          return;
        end
      end else begin
        done = close_levels();
      end
      tag_waiting = 1'b0;
      note(K_HEAD, mt, ai, a, 1'b0, 8'd0, done, E_NONE);
      return;
    end
    tag_waiting = 1'b0;
    if ((mt == MT_BSTR || mt == MT_TSTR) && a != 0) begin
      payload_left = a;
      phase = PH_PAYLOAD;
    end else begin
      done = close_levels();
    end
    note(K_HEAD, mt, ai, a, 1'b0, 8'd0, done, E_NONE);
  endfunction

  function automatic void head_in(logic [7:0] b);
    logic [2:0] mt;
    logic [4:0] ai;
    bit         done;
    mt = b[7:5];
    ai = b[4:0];
    held_head = b;
    // break byte
    if (b == BREAK_BYTE) begin
      if (in_chunked) begin
        in_chunked = 1'b0;
        done = close_levels();
        note(K_BREAK, MT_SIMPLE, AI_INDEF, 64'd0, 1'b0, 8'd0, done, E_NONE);
        return;
      end
      if (tag_waiting || depth_now == 0 || !level_open_ended[depth_now-1]) begin
        raise(E_BREAK);
        return;
      end
      depth_now--;
      done = close_levels();
      note(K_BREAK, MT_SIMPLE, AI_INDEF, 64'd0, 1'b0, 8'd0, done, E_NONE);
      return;
    end
    // chunk rules
    if (in_chunked) begin
      if (mt != chunked_type) begin
        raise(E_CHUNK);
        return;
      end
      if (ai == AI_INDEF) begin
        raise(E_NESTED);
        return;
      end
    end
    if (ai >= AI_RSV_LO && ai <= AI_RSV_HI) begin
      raise(E_RESERVED);
      return;
    end
    if (ai == AI_INDEF) begin
      if (mt == MT_BSTR || mt == MT_TSTR) begin
        in_chunked = 1'b1;
        chunked_type = mt;
        tag_waiting = 1'b0;
        note(K_HEAD, mt, ai, 64'd0, 1'b1, 8'd0, 1'b0, E_NONE);
        return;
      end
      if (mt == MT_ARRAY || mt == MT_MAP) begin
        if (!open_level(64'd0, 1'b1)) begin
          raise(E_OVERFLOW);
          return;
        end
        tag_waiting = 1'b0;
        note(K_HEAD, mt, ai, 64'd0, 1'b1, 8'd0, 1'b0, E_NONE);
        return;
      end
      raise(E_BAD_INDEF);
      return;
    end
    // argument bytes follow
    if (ai >= AI_ARG1) begin
      arg_left = 1 << (ai - AI_ARG1);
      arg_acc = 64'd0;
      phase = PH_ARG;
      return;
    end
    finish_head(b, {59'd0, ai});
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic e);
    bit done;
    if (halted) return;
    if (e) begin
      if (phase == PH_HEAD && depth_now == 0 && !in_chunked && !tag_waiting)
        note(K_END, 3'd0, 5'd0, 64'd0, 1'b0, 8'd0, 1'b0, E_NONE);
      else
        raise(E_TRUNC);
      return;
    end
    if (phase == PH_ARG) begin
      arg_acc = {arg_acc[55:0], b};
      arg_left--;
      if (arg_left == 0) finish_head(held_head, arg_acc);
      return;
    end
    if (phase == PH_PAYLOAD) begin
      done = 1'b0;
      payload_left = payload_left - 1;
      if (payload_left == 0) begin
        phase = PH_HEAD;
        if (!in_chunked) done = close_levels();
      end
      note(K_PAYLOAD, held_head[7:5], held_head[4:0], 64'd0, 1'b0, b, done, E_NONE);
      return;
    end
    head_in(b);
  endfunction

  // ------------------------------------------------------------------
  // stream building
  // ------------------------------------------------------------------
  function automatic void put(logic [7:0] b);
    stim_q.insert(stim_q.size(), {1'b0, b});
  endfunction

  function automatic void put_end();
    logic [7:0] junk;
    junk = 8'($urandom);
    stim_q.insert(stim_q.size(), {1'b1, junk});
  endfunction

  // form 0 puts the value in the head, forms 1..4 use 1, 2, 4 or 8 bytes
  function automatic void put_head(logic [2:0] mt, logic [63:0] val, int form);
    int nb;
    if (form == 0) begin
      put({mt, val[4:0]});
      return;
    end
    nb = 1 << (form - 1);
    put({mt, 5'(23 + form)});
    for (int i = nb - 1; i >= 0; i--) put(val[i*8 +: 8]);
  endfunction

  function automatic void put_len(logic [2:0] mt, int n);
    put_head(mt, 64'(n), (n < 24) ? $urandom_range(0, 4) : $urandom_range(1, 4));
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void put_scalar(logic [2:0] mt);
    int form;
    form = $urandom_range(0, 4);
    if (form == 0) put_head(mt, 64'($urandom_range(0, 23)), 0);
    else put_head(mt, rand_word(), form);
  endfunction

  function automatic void put_string(logic [2:0] mt);
    int n;
    int chunks;
    if ($urandom_range(0, 3) == 0) begin
      put({mt, AI_INDEF});
      chunks = $urandom_range(0, 3);
      repeat (chunks) begin
        n = $urandom_range(0, 3);
        put_len(mt, n);
        repeat (n) put(8'($urandom));
      end
      put(BREAK_BYTE);
    end else begin
      n = $urandom_range(0, 5);
      put_len(mt, n);
      repeat (n) put(8'($urandom));
    end
  endfunction

  function automatic void put_item(int depth);
    int sel;
    int n;
    logic [2:0] mt;
    sel = $urandom_range(0, 11);
    if (depth >= 4 && (sel == 3 || sel == 4)) sel = 0;
    if (depth >= DEPTH && sel == 7) sel = 1;
    case (sel)
      0, 1: begin
        put_scalar(sel == 0 ? MT_UINT : MT_NINT);
      end
      2, 8: begin
        put_string($urandom_range(0, 1) ? MT_TSTR : MT_BSTR);
      end
      3, 4: begin
        mt = (sel == 3) ? MT_ARRAY : MT_MAP;
        n = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) begin
          put({mt, AI_INDEF});
          repeat (mt == MT_MAP ? 2 * n : n) put_item(depth + 1);
          put(BREAK_BYTE);
        end else begin
          put_len(mt, n);
          repeat (mt == MT_MAP ? 2 * n : n) put_item(depth + 1);
        end
      end
      5: begin
        put_scalar(MT_TAG);
        put_item(depth);
      end
      6, 9: begin
        put_scalar(MT_SIMPLE);
      end
      7: begin
        // single-entry array chain, reaches deep nesting cheaply
        put_len(MT_ARRAY, 1);
        put_item(depth + 1);
      end
      default: begin
        put_head(MT_UINT, 64'($urandom_range(0, 23)), 0);
      end
    endcase
  endfunction

  // ------------------------------------------------------------------
  // driving
  // ------------------------------------------------------------------
  task automatic send_item(logic [7:0] b, logic e);
    while (!no_idle && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    stream_end <= e;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(b, e);
    if (e) ends_sent++;
    else bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_queued();
    logic [8:0] s;
    while (stim_q.size() != 0) begin
      s = stim_q.pop_front();
      send_item(s[7:0], s[8]);
    end
  endtask

  // stop offering and wait for every predicted token
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (2 * DEPTH + 8) @(negedge clk);
  endtask

  // receiver: random stalls, long hold-offs on request
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= 17);
    end
  end

  // token checker
  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{token_kind, major_type, additional_info, argument, indefinite,
              data_byte, nesting_level, item_done, error_code};
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        fails++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected token: kind %0d major %0d info %0d arg %h err %0d",
                   got.kind, got.major, got.info, got.arg, got.err);
        end
      end else begin
        want = expected_tokens.pop_front();
        if (got.kind != want.kind || got.major != want.major ||
            got.info != want.info || got.arg != want.arg ||
            got.indef != want.indef || got.data != want.data ||
            got.level != want.level || got.done != want.done ||
            got.err != want.err) begin
          fails++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("token mismatch at %0t", $realtime);
            $display("  expected kind %0d major %0d info %0d arg %h indef %0d",
                     want.kind, want.major, want.info, want.arg, want.indef);
            $display("           data %h lvl %0d done %0d err %0d",
                     want.data, want.level, want.done, want.err);
            $display("  actual   kind %0d major %0d info %0d arg %h indef %0d",
                     got.kind, got.major, got.info, got.arg, got.indef);
            $display("           data %h lvl %0d done %0d err %0d",
                     got.data, got.level, got.done, got.err);
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  task automatic test_directed_items();
    put_head(MT_UINT, 64'd0, 0);
    put_head(MT_UINT, 64'd23, 0);
    put_head(MT_UINT, '1, 4);
    put_head(MT_NINT, '1, 4);
    put_head(MT_NINT, 64'h80, 1);
    put_len(MT_BSTR, 0);
    put_len(MT_TSTR, 2);
    put(8'h00);
    put(8'hFF);
    put({MT_TSTR, AI_INDEF});
    put_len(MT_TSTR, 1);
    put(8'h41);
    put_len(MT_TSTR, 0);
    put(BREAK_BYTE);
    put_len(MT_ARRAY, 0);
    put_len(MT_MAP, 0);
    put_end();
    put({MT_MAP, AI_INDEF});
    put_head(MT_UINT, 64'd1, 0);
    put({MT_ARRAY, AI_INDEF});
    put(BREAK_BYTE);
    put(BREAK_BYTE);
    put_head(MT_TAG, 64'h0102_0304, 3);
    put_head(MT_SIMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 4);
    put_head(MT_SIMPLE, 64'd20, 0);
    put_end();
    send_queued();
  endtask

  task automatic test_deep_nesting();
    repeat (DEPTH) put_len(MT_ARRAY, 1);
    put_head(MT_UINT, 64'd5, 0);
    repeat (DEPTH) put({MT_ARRAY, AI_INDEF});
    put_head(MT_UINT, 64'd6, 0);
    repeat (DEPTH) put(BREAK_BYTE);
    put_end();
    send_queued();
  endtask

  task automatic test_random_stream();
    int start;
    start = bytes_sent;
    no_idle = 1'b1;
    while (stim_q.size() < 300) put_item(0);
    send_queued();
    no_idle = 1'b0;
    while (bytes_sent - start < 1700) begin
      put_item(0);
      if ($urandom_range(0, 5) == 0) put_end();
      send_queued();
    end
  endtask

  task automatic test_output_hold();
    hold_reqs++;
    no_idle = 1'b1;
    while (stim_q.size() < 150) put_item(0);
    send_queued();
    no_idle = 1'b0;
  endtask

  task automatic test_error_case();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: put({MT_UINT, AI_RSV_LO + 5'($urandom_range(0, 2))});
      1: put({MT_TAG, AI_INDEF});
      2: begin
        put({MT_BSTR, AI_INDEF});
        put_len(MT_TSTR, 1);
      end
      3: begin
        put({MT_TSTR, AI_INDEF});
        put({MT_TSTR, AI_INDEF});
      end
      4: put(BREAK_BYTE);
      5: repeat (DEPTH + 1) put({MT_ARRAY, AI_INDEF});
      6: put_head(MT_MAP, {1'b1, 63'($urandom)}, 4);
      default: begin
        put_len(MT_ARRAY, 2);
        put_head(MT_UINT, 64'd1, 0);
        put_end();
      end
    endcase
    // nothing more may come out after the error
    repeat (4) put(8'($urandom));
    put_end();
    send_queued();
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_byte    = 8'd0;
    stream_end = 1'b0;
    phase = PH_HEAD;
    arg_left = 0;
    arg_acc = 64'd0;
    held_head = 8'd0;
    payload_left = 64'd0;
    in_chunked = 1'b0;
    chunked_type = 3'd0;
    depth_now = 0;
    tag_waiting = 1'b0;
    halted = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_items();
    test_deep_nesting();
    test_random_stream();
    test_output_hold();
    drain();
    test_error_case();
    drain();

    if (expected_tokens.size() != 0) fails++;
    $display("covered %0d stream bytes, %0d end marks, %0d tokens checked",
             bytes_sent, ends_sent, tokens_seen);
    $display("nesting to depth %0d, output hold-off, one error scenario at the end",
             DEPTH);
    if (fails == 0) begin
      $display("cbor_stream_tokenizer_test: PASS");
    end else begin
      $display("cbor_stream_tokenizer_test: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #30ms;
    $display("cbor_stream_tokenizer_test: FAIL");
    $finish;
  end

endmodule
